/* hdl/ipsv_pkg.sv */
// ============================================================================
// ipsv_pkg - shared types and constants
// Stage payload types, sector codes, register indexes and fixed-point
// constants for the inverse Park / space-vector PWM pipeline.
// ============================================================================
package ipsv_pkg;

    // Fixed-point constants (Q15)
    localparam logic [14:0] SQRT3_HALF = 15'd28377;
    localparam int          Q_SHIFT    = 15;
    localparam int          HALF_SHIFT = 14;           // x * 16384 as a shift
    localparam logic [15:0] K_UNITY    = 16'h8000;     // 1.0 in Q15, no rescale

    // Pipeline shape
    localparam int DIV_STAGES = 5;
    localparam int DIV_STEP   = 3;                     // quotient bits per stage
    localparam int LATENCY    = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_PERIOD = 2'd0;
    localparam logic [1:0] CFG_UPPER  = 2'd1;
    localparam logic [1:0] CFG_LOWER  = 2'd2;

    // Sector codes; comment gives the channel that takes ta / tb / tc
    localparam logic [2:0] SEC_0 = 3'd0;   // a=ta b=tb c=tc
    localparam logic [2:0] SEC_1 = 3'd1;   // b=ta c=tb a=tc
    localparam logic [2:0] SEC_2 = 3'd2;   // b=ta a=tb c=tc
    localparam logic [2:0] SEC_3 = 3'd3;   // c=ta a=tb b=tc
    localparam logic [2:0] SEC_4 = 3'd4;   // a=ta c=tb b=tc
    localparam logic [2:0] SEC_5 = 3'd5;   // c=ta b=tb a=tc

    // Sector and the two vector magnitudes
    typedef struct packed {
        logic        valid;
        logic [2:0]  sector;
        logic [16:0] t1;
        logic [16:0] t2;
    } t_sel;

    // Period-scaled active times ahead of the divider
    typedef struct packed {
        logic        valid;
        logic [2:0]  sector;
        logic [16:0] s1;
        logic [16:0] s2;
        logic [17:0] sum;
        logic        over;
    } t_div;

    // Active times and their rescale factor
    typedef struct packed {
        logic        valid;
        logic [2:0]  sector;
        logic [16:0] s1;
        logic [16:0] s2;
        logic [15:0] k;
    } t_scl;

    // Divider partial remainder and quotient
    typedef struct packed {
        logic [17:0] rem;
        logic [14:0] quo;
    } t_dacc;

endpackage

/* hdl/inverse_park_space_vector_pwm.sv */
// ============================================================================
// inverse_park_space_vector_pwm - inverse Park transform and space-vector PWM
// Turns a d/q voltage reference and rotor angle sine/cosine into three
// clamped centre-aligned compare values.
// ============================================================================
// Usage:
//   Command channel: drive the four input fields and pulse start; a beat is
//   taken on any edge with start high and busy low. busy stays low, so a new
//   beat may be offered every cycle.
//   Result channel: o_strobe is high for one cycle with the three duties;
//   the receiver cannot hold results off and must take them as they come.
//   Throughput is one beat per cycle. The sixteen stages are the inverse Park
//   products, reference voltages, sector decode, period scaling, a five-stage
//   divider for the overmodulation factor, then compare values, routing and
//   the clamp.
//   Config channel: i_cfg_valid/o_cfg_ready with index and data; index 0 is
//   the PWM period, 1 the upper limit, 2 the lower limit. Write only while
//   no beat is in flight. Unknown indexes are ignored.
//   Reset: synchronous and active low; it empties the pipeline and sets the
//   period to 0, the upper limit to 65535 and the lower limit to 0.
// ============================================================================
module inverse_park_space_vector_pwm import ipsv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_volt_direct,
    input  logic signed [15:0] i_volt_quad,
    input  logic signed [15:0] i_angle_sine,
    input  logic signed [15:0] i_angle_cosine,
    output logic               o_strobe,
    output logic        [15:0] o_duty_phase_a,
    output logic        [15:0] o_duty_phase_b,
    output logic        [15:0] o_duty_phase_c,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic         [1:0] i_cfg_index,
    input  logic        [15:0] i_cfg_data
);

    logic [15:0] r_period, r_upper, r_lower;
    logic [15:0] n_period, n_upper, n_lower;
    logic        accept;

    t_sel sel;
    t_div div;
    t_scl scl;

    // Pipeline never backs up
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Decode register writes
    always_comb begin
        n_period = r_period;
        n_upper  = r_upper;
        n_lower  = r_lower;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PERIOD: n_period = i_cfg_data;
                CFG_UPPER:  n_upper  = i_cfg_data;
                CFG_LOWER:  n_lower  = i_cfg_data;
                default:    n_period = r_period;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_upper  <= '1;
            r_lower  <= '0;
        end else begin
            r_period <= n_period;
            r_upper  <= n_upper;
            r_lower  <= n_lower;
        end
    end

    ipsv_transform u_transform (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_volt_direct  (i_volt_direct),
        .i_volt_quad    (i_volt_quad),
        .i_angle_sine   (i_angle_sine),
        .i_angle_cosine (i_angle_cosine),
        .o_sel          (sel)
    );

    ipsv_times u_times (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sel    (sel),
        .i_period (r_period),
        .o_div    (div)
    );

    ipsv_divider u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_div    (div),
        .i_period (r_period),
        .o_scl    (scl)
    );

    ipsv_duty u_duty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scl    (scl),
        .i_period (r_period),
        .i_upper  (r_upper),
        .i_lower  (r_lower),
        .o_strobe (o_strobe),
        .o_duty_a (o_duty_phase_a),
        .o_duty_b (o_duty_phase_b),
        .o_duty_c (o_duty_phase_c)
    );

    // Every accepted beat yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("result missing after pipeline latency");

    // Each channel lands on a limit or between them
    a_limit_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_duty_phase_a == r_upper) || (o_duty_phase_a == r_lower) ||
                     ((o_duty_phase_a >= r_lower) && (o_duty_phase_a <= r_upper)))
        else $error("phase A outside limits");

    a_limit_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_duty_phase_b == r_upper) || (o_duty_phase_b == r_lower) ||
                     ((o_duty_phase_b >= r_lower) && (o_duty_phase_b <= r_upper)))
        else $error("phase B outside limits");

    a_limit_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_duty_phase_c == r_upper) || (o_duty_phase_c == r_lower) ||
                     ((o_duty_phase_c >= r_lower) && (o_duty_phase_c <= r_upper)))
        else $error("phase C outside limits");

endmodule

/* hdl/ipsv_transform.sv */
// ============================================================================
// ipsv_transform - inverse Park, reference voltages and sector decode
// Five register stages: d/q products, alpha/beta, scaled terms, the three
// reference voltages, then sector choice and the two vector magnitudes.
// ============================================================================
module ipsv_transform import ipsv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_volt_direct,
    input  logic signed [15:0] i_volt_quad,
    input  logic signed [15:0] i_angle_sine,
    input  logic signed [15:0] i_angle_cosine,
    output t_sel               o_sel
);

    // Stage registers
    logic               r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [31:0] r_p_dc, r_p_qs, r_p_ds, r_p_qc;
    logic signed [16:0] r_alpha, r_beta2;
    logic signed [31:0] r_a_term, r_b_term;
    logic signed [16:0] r_beta3;
    logic signed [16:0] r_r1, r_r2, r_r3;
    logic [2:0]         r_sector;
    logic [16:0]        r_t1, r_t2;

    // Next values
    logic signed [31:0] n_p_dc, n_p_qs, n_p_ds, n_p_qc;
    logic signed [31:0] n_diff, n_sum;
    logic signed [31:0] n_a_term, n_b_term;
    logic signed [31:0] n_r2_full, n_r3_full;
    logic [2:0]         n_sector;
    logic [16:0]        n_t1, n_t2;
    logic [2:0]         sgn;

    // Stage 1: rotation products
    assign n_p_dc = i_volt_direct * i_angle_cosine;
    assign n_p_qs = i_volt_quad   * i_angle_sine;
    assign n_p_ds = i_volt_direct * i_angle_sine;
    assign n_p_qc = i_volt_quad   * i_angle_cosine;

    // Stage 2: alpha and beta, wrap at 32 bits then shift down
    assign n_diff = r_p_dc - r_p_qs;
    assign n_sum  = r_p_ds + r_p_qc;

    // Stage 3: scale alpha by sqrt(3)/2 and beta by one half, negated
    assign n_a_term = 32'(r_alpha) * $signed({1'b0, SQRT3_HALF});
    assign n_b_term = -(32'(r_beta2) <<< HALF_SHIFT);

    // Stage 4: second and third reference voltages
    assign n_r2_full = r_a_term + r_b_term;
    assign n_r3_full = r_b_term - r_a_term;

    // Stage 5: pick sector from the signs, take magnitudes
    assign sgn = {r_r1[16], r_r2[16], r_r3[16]};

    always_comb begin
        n_sector = SEC_0;
        n_t1     = 17'(r_r2);
        n_t2     = 17'(r_r1);
        unique case (sgn) inside
            3'b000, 3'b001: begin
                n_sector = SEC_0;
                n_t1     = 17'(r_r2);
                n_t2     = 17'(r_r1);
            end
            3'b010: begin
                n_sector = SEC_1;
                n_t1     = 17'(r_r1);
                n_t2     = 17'(r_r3);
            end
            3'b011: begin
                n_sector = SEC_2;
                n_t1     = 17'(-r_r2);
                n_t2     = 17'(-r_r3);
            end
            3'b100: begin
                n_sector = SEC_3;
                n_t1     = 17'(r_r3);
                n_t2     = 17'(r_r2);
            end
            3'b101: begin
                n_sector = SEC_4;
                n_t1     = 17'(-r_r3);
                n_t2     = 17'(-r_r1);
            end
            3'b110, 3'b111: begin
                n_sector = SEC_5;
                n_t1     = 17'(-r_r1);
                n_t2     = 17'(-r_r2);
            end
            default: begin
                n_sector = SEC_0;
            end
        endcase
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_p_dc   <= n_p_dc;
        r_p_qs   <= n_p_qs;
        r_p_ds   <= n_p_ds;
        r_p_qc   <= n_p_qc;
        r_alpha  <= $signed(n_diff[31:Q_SHIFT]);
        r_beta2  <= $signed(n_sum[31:Q_SHIFT]);
        r_a_term <= n_a_term;
        r_b_term <= n_b_term;
        r_beta3  <= r_beta2;
        r_r1     <= r_beta3;
        r_r2     <= $signed(n_r2_full[31:Q_SHIFT]);
        r_r3     <= $signed(n_r3_full[31:Q_SHIFT]);
        r_sector <= n_sector;
        r_t1     <= n_t1;
        r_t2     <= n_t2;
    end

    assign o_sel.valid  = r_v5;
    assign o_sel.sector = r_sector;
    assign o_sel.t1     = r_t1;
    assign o_sel.t2     = r_t2;

endmodule

/* hdl/ipsv_times.sv */
// ============================================================================
// ipsv_times - active times scaled by the PWM period
// Two register stages: period products, then their sum and the
// overmodulation test.
// ============================================================================
module ipsv_times import ipsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sel        i_sel,
    input  logic [15:0] i_period,
    output t_div        o_div
);

    logic        r_v1, r_v2;
    logic [2:0]  r_sec1, r_sec2;
    logic [16:0] r_s1a, r_s2a, r_s1b, r_s2b;
    logic [17:0] r_sum;
    logic        r_over;

    logic [32:0] n_prod1, n_prod2;
    logic [17:0] n_sum;

    // Scale both magnitudes by the period; products stay below 2^32
    assign n_prod1 = {16'b0, i_sel.t1} * {17'b0, i_period};
    assign n_prod2 = {16'b0, i_sel.t2} * {17'b0, i_period};

    // Sum the scaled times for the overmodulation test
    assign n_sum = {1'b0, r_s1a} + {1'b0, r_s2a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_sel.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec1 <= i_sel.sector;
        r_s1a  <= n_prod1[31:Q_SHIFT];
        r_s2a  <= n_prod2[31:Q_SHIFT];
        r_sec2 <= r_sec1;
        r_s1b  <= r_s1a;
        r_s2b  <= r_s2a;
        r_sum  <= n_sum;
        r_over <= (n_sum > {2'b0, i_period});
    end

    assign o_div.valid  = r_v2;
    assign o_div.sector = r_sec2;
    assign o_div.s1     = r_s1b;
    assign o_div.s2     = r_s2b;
    assign o_div.sum    = r_sum;
    assign o_div.over   = r_over;

endmodule

/* hdl/ipsv_divider.sv */
// ============================================================================
// ipsv_divider - pipelined restoring divider for the rescale factor
// Computes (period << 15) / sum a few quotient bits per stage. The quotient
// is below 2^15 whenever the sum exceeds the period; otherwise the factor
// falls back to unity.
// ============================================================================
module ipsv_divider import ipsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div        i_div,
    input  logic [15:0] i_period,
    output t_scl        o_scl
);

    logic        r_vld  [DIV_STAGES];
    t_dacc       r_acc  [DIV_STAGES];
    logic [2:0]  r_sec  [DIV_STAGES];
    logic [16:0] r_s1   [DIV_STAGES];
    logic [16:0] r_s2   [DIV_STAGES];
    logic [17:0] r_den  [DIV_STAGES];
    logic        r_over [DIV_STAGES];

    t_dacc       n_acc  [DIV_STAGES];
    t_dacc       acc_init;

    // Shift in zero numerator bits, subtract where the divisor fits
    function automatic t_dacc div_steps(t_dacc acc, logic [17:0] den);
        t_dacc       res;
        logic [18:0] shifted;
        res = acc;
        for (int j = 0; j < DIV_STEP; j++) begin
            shifted = {res.rem, 1'b0};
            if (shifted >= {1'b0, den}) begin
                res.rem = 18'(shifted - {1'b0, den});
                res.quo = {res.quo[13:0], 1'b1};
            end else begin
                res.rem = shifted[17:0];
                res.quo = {res.quo[13:0], 1'b0};
            end
        end
        return res;
    endfunction

    // Upper numerator bits are the period itself
    assign acc_init.rem = {2'b0, i_period};
    assign acc_init.quo = '0;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign n_acc[g] = div_steps(acc_init, i_div.sum);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else begin
                    r_vld[g] <= i_div.valid;
                end
            end

            always_ff @(posedge i_clk) begin
                r_acc[g]  <= n_acc[g];
                r_sec[g]  <= i_div.sector;
                r_s1[g]   <= i_div.s1;
                r_s2[g]   <= i_div.s2;
                r_den[g]  <= i_div.sum;
                r_over[g] <= i_div.over;
            end
        end else begin : g_next
            assign n_acc[g] = div_steps(r_acc[g-1], r_den[g-1]);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else begin
                    r_vld[g] <= r_vld[g-1];
                end
            end

            always_ff @(posedge i_clk) begin
                r_acc[g]  <= n_acc[g];
                r_sec[g]  <= r_sec[g-1];
                r_s1[g]   <= r_s1[g-1];
                r_s2[g]   <= r_s2[g-1];
                r_den[g]  <= r_den[g-1];
                r_over[g] <= r_over[g-1];
            end
        end
    end

    assign o_scl.valid  = r_vld[DIV_STAGES-1];
    assign o_scl.sector = r_sec[DIV_STAGES-1];
    assign o_scl.s1     = r_s1[DIV_STAGES-1];
    assign o_scl.s2     = r_s2[DIV_STAGES-1];
    assign o_scl.k      = r_over[DIV_STAGES-1] ? {1'b0, r_acc[DIV_STAGES-1].quo}
                                               : K_UNITY;

endmodule

/* hdl/ipsv_duty.sv */
// ============================================================================
// ipsv_duty - rescale, centre-aligned compare values, routing and clamp
// Four register stages: rescale products, centre value, edge values, then
// per-sector channel routing and the limit clamp into the output register.
// ============================================================================
module ipsv_duty import ipsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_scl        i_scl,
    input  logic [15:0] i_period,
    input  logic [15:0] i_upper,
    input  logic [15:0] i_lower,
    output logic        o_strobe,
    output logic [15:0] o_duty_a,
    output logic [15:0] o_duty_b,
    output logic [15:0] o_duty_c
);

    logic        r_va, r_vb, r_vc, r_vd;
    logic [2:0]  r_seca, r_secb, r_secc;
    logic [16:0] r_s1, r_s2;
    logic [15:0] r_tc_b, r_tot, r_s2_b;
    logic [15:0] r_ta, r_tb, r_tc;
    logic [15:0] r_duty_a, r_duty_b, r_duty_c;

    logic [32:0] n_prod1, n_prod2;
    logic [17:0] n_tot, n_gap;
    logic [15:0] n_ta, n_tb;
    logic [15:0] n_ch_a, n_ch_b, n_ch_c;

    function automatic logic [15:0] clamp(logic [15:0] v, logic [15:0] hi,
                                          logic [15:0] lo);
        logic [15:0] res;
        if (v > hi) begin
            res = hi;
        end else if (v < lo) begin
            res = lo;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Stage A: rescale both times by k in Q15
    assign n_prod1 = {16'b0, i_scl.s1} * {17'b0, i_scl.k};
    assign n_prod2 = {16'b0, i_scl.s2} * {17'b0, i_scl.k};

    // Stage B: total active time and the centre value; total never passes period
    assign n_tot = {1'b0, r_s1} + {1'b0, r_s2};
    assign n_gap = {2'b0, i_period} - n_tot;

    // Stage C: edge values, none of which passes the period
    assign n_tb = r_tc_b + r_s2_b;
    assign n_ta = r_tc_b + r_tot;

    // Stage D: route to channels by sector
    always_comb begin
        n_ch_a = r_ta;
        n_ch_b = r_tb;
        n_ch_c = r_tc;
        unique case (r_secc)
            SEC_0: begin
                n_ch_a = r_ta; n_ch_b = r_tb; n_ch_c = r_tc;
            end
            SEC_1: begin
                n_ch_a = r_tc; n_ch_b = r_ta; n_ch_c = r_tb;
            end
            SEC_2: begin
                n_ch_a = r_tb; n_ch_b = r_ta; n_ch_c = r_tc;
            end
            SEC_3: begin
                n_ch_a = r_tb; n_ch_b = r_tc; n_ch_c = r_ta;
            end
            SEC_4: begin
                n_ch_a = r_ta; n_ch_b = r_tc; n_ch_c = r_tb;
            end
            SEC_5: begin
                n_ch_a = r_tc; n_ch_b = r_tb; n_ch_c = r_ta;
            end
            default: begin
                n_ch_a = r_ta; n_ch_b = r_tb; n_ch_c = r_tc;
            end
        endcase
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_scl.valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_seca   <= i_scl.sector;
        r_s1     <= n_prod1[31:Q_SHIFT];
        r_s2     <= n_prod2[31:Q_SHIFT];
        r_secb   <= r_seca;
        r_tot    <= n_tot[15:0];
        r_s2_b   <= r_s2[15:0];
        r_tc_b   <= n_gap[16:1];
        r_secc   <= r_secb;
        r_ta     <= n_ta;
        r_tb     <= n_tb;
        r_tc     <= r_tc_b;
        r_duty_a <= clamp(n_ch_a, i_upper, i_lower);
        r_duty_b <= clamp(n_ch_b, i_upper, i_lower);
        r_duty_c <= clamp(n_ch_c, i_upper, i_lower);
    end

    assign o_strobe = r_vd;
    assign o_duty_a = r_duty_a;
    assign o_duty_b = r_duty_b;
    assign o_duty_c = r_duty_c;

    // Edge values keep their order: ta >= tb >= tc
    a_edge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc |-> (r_ta >= r_tb) && (r_tb >= r_tc))
        else $error("edge values out of order");

endmodule
